// File: rtl/pixel_denormalize_with_range_stats_core_macros.svh
// Assertion macros for the pixel denormalizer checker.
// Included by the checker file only; no other dependencies.
`ifndef PIXEL_DENORMALIZE_WITH_RANGE_STATS_CORE_MACROS_SVH
`define PIXEL_DENORMALIZE_WITH_RANGE_STATS_CORE_MACROS_SVH

// checked only out of reset
`define PDRS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define PDRS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/pdrs_pkg.sv
// Shared types and constants for the pixel denormalizer.
// No dependencies; used by every RTL file of the block but the macro header.
package pdrs_pkg;

  localparam int unsigned NumChan      = 3;
  localparam int unsigned DataW        = 16;
  localparam int unsigned CountOutW    = 32;
  localparam int unsigned CountWidthDef = 32;
  localparam int unsigned PaddrW       = 5;
  localparam int unsigned PdataW       = 32;

  localparam logic [DataW-1:0] OneQ15 = 16'h8000;

  localparam logic [DataW-1:0] GainRedRst    = 16'd15008;
  localparam logic [DataW-1:0] GainGreenRst  = 16'd14680;
  localparam logic [DataW-1:0] GainBlueRst   = 16'd14746;
  localparam logic [DataW-1:0] OffsetRedRst  = 16'd15893;
  localparam logic [DataW-1:0] OffsetGreenRst = 16'd14942;
  localparam logic [DataW-1:0] OffsetBlueRst = 16'd13304;

  typedef enum logic [2:0] {
    REG_GAIN_RED     = 3'd0,
    REG_GAIN_GREEN   = 3'd1,
    REG_GAIN_BLUE    = 3'd2,
    REG_OFFSET_RED   = 3'd3,
    REG_OFFSET_GREEN = 3'd4,
    REG_OFFSET_BLUE  = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2,
    CH_NONE  = 2'd3
  } chan_e;

  typedef struct packed {
    logic [NumChan-1:0][DataW-1:0] gain;
    logic [NumChan-1:0][DataW-1:0] offset;
  } pdrs_cfg_t;

  // control that travels with the product into the result stage
  typedef struct packed {
    logic valid;
    logic invalid;
    logic start;
    logic chan_ok;
  } pdrs_ctl_t;

endpackage

// File: rtl/pdrs_ifs.sv
// Stream interfaces for the pixel denormalizer: input and result words.
// Depends on pdrs_pkg for widths.
interface pdrs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pdrs_pkg::DataW-1:0]   sample;
  logic [1:0]                          color_channel;
  logic                                sample_invalid;
  logic                                frame_start;

  modport source (output valid, sample, color_channel, sample_invalid, frame_start,
                  input ready);
  modport sink   (input valid, sample, color_channel, sample_invalid, frame_start,
                  output ready);
endinterface

interface pdrs_out_if;
  logic                                valid;
  logic                                ready;
  logic [pdrs_pkg::DataW-1:0]          pixel_value;
  logic                                pixel_invalid;
  logic [pdrs_pkg::DataW-1:0]          range_minimum;
  logic [pdrs_pkg::DataW-1:0]          range_maximum;
  logic                                range_seen;
  logic [pdrs_pkg::CountOutW-1:0]      invalid_count;

  modport source (output valid, pixel_value, pixel_invalid, range_minimum, range_maximum,
                  range_seen, invalid_count, input ready);
  modport sink   (input valid, pixel_value, pixel_invalid, range_minimum, range_maximum,
                  range_seen, invalid_count, output ready);
endinterface

// File: rtl/pdrs_cfg.sv
// APB register file: per-channel gains and offsets.
// Depends on pdrs_pkg.
module pdrs_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdrs_pkg::PaddrW-1:0]   paddr,
  input  logic [pdrs_pkg::PdataW-1:0]   pwdata,
  output logic [pdrs_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  output pdrs_pkg::pdrs_cfg_t           cfg_o
);
  import pdrs_pkg::*;

  pdrs_cfg_t cfg_q;
  reg_idx_e  idx;
  logic      wr_en;

  assign idx    = reg_idx_e'(paddr[PaddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain[0]   <= GainRedRst;
      cfg_q.gain[1]   <= GainGreenRst;
      cfg_q.gain[2]   <= GainBlueRst;
      cfg_q.offset[0] <= OffsetRedRst;
      cfg_q.offset[1] <= OffsetGreenRst;
      cfg_q.offset[2] <= OffsetBlueRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN_RED:     cfg_q.gain[0]   <= pwdata[DataW-1:0];
        REG_GAIN_GREEN:   cfg_q.gain[1]   <= pwdata[DataW-1:0];
        REG_GAIN_BLUE:    cfg_q.gain[2]   <= pwdata[DataW-1:0];
        REG_OFFSET_RED:   cfg_q.offset[0] <= pwdata[DataW-1:0];
        REG_OFFSET_GREEN: cfg_q.offset[1] <= pwdata[DataW-1:0];
        REG_OFFSET_BLUE:  cfg_q.offset[2] <= pwdata[DataW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_GAIN_RED:     prdata[DataW-1:0] = cfg_q.gain[0];
      REG_GAIN_GREEN:   prdata[DataW-1:0] = cfg_q.gain[1];
      REG_GAIN_BLUE:    prdata[DataW-1:0] = cfg_q.gain[2];
      REG_OFFSET_RED:   prdata[DataW-1:0] = cfg_q.offset[0];
      REG_OFFSET_GREEN: prdata[DataW-1:0] = cfg_q.offset[1];
      REG_OFFSET_BLUE:  prdata[DataW-1:0] = cfg_q.offset[2];
      default:          prdata = '0;
    endcase
  end

endmodule

// File: rtl/pdrs_scale.sv
// Scale path: input register with channel select, product register, then
// round, offset and clamp. Depends on pdrs_pkg.
module pdrs_scale (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              in_valid_i,
  input  logic signed [pdrs_pkg::DataW-1:0] sample_i,
  input  logic [1:0]                        chan_i,
  input  logic                              invalid_i,
  input  logic                              start_i,
  input  pdrs_pkg::pdrs_cfg_t               cfg_i,
  output logic [pdrs_pkg::DataW-1:0]        value_o,
  output pdrs_pkg::pdrs_ctl_t               ctl_o
);
  import pdrs_pkg::*;

  // stage 1
  pdrs_ctl_t                ctl1_q;
  logic signed [DataW-1:0]  sample_q;
  logic [DataW-1:0]         gain1_q, off1_q;
  logic [DataW-1:0]         gain_sel, off_sel;
  // stage 2
  pdrs_ctl_t                ctl2_q;
  logic signed [31:0]       prod_q, prod_d;
  logic [DataW-1:0]         off2_q;
  // result math
  logic signed [31:0]       biased;
  logic signed [18:0]       shifted;
  logic signed [19:0]       sum;

  always_comb begin
    gain_sel = '0;
    off_sel  = '0;
    case (chan_e'(chan_i))
      CH_RED:   begin gain_sel = cfg_i.gain[0]; off_sel = cfg_i.offset[0]; end
      CH_GREEN: begin gain_sel = cfg_i.gain[1]; off_sel = cfg_i.offset[1]; end
      CH_BLUE:  begin gain_sel = cfg_i.gain[2]; off_sel = cfg_i.offset[2]; end
      default:  begin gain_sel = '0;            off_sel = '0;            end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl1_q.valid   <= in_valid_i;
      ctl1_q.invalid <= invalid_i;
      ctl1_q.start   <= start_i;
      ctl1_q.chan_ok <= (chan_e'(chan_i) != CH_NONE);
      ctl2_q         <= ctl1_q;
    end
  end

  // |product| < 2^31, fits 32 bits signed
  assign prod_d = 32'(sample_q * $signed({1'b0, gain1_q}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sample_q <= sample_i;
      gain1_q  <= gain_sel;
      off1_q   <= off_sel;
      prod_q   <= prod_d;
      off2_q   <= off1_q;
    end
  end

  // round half up, >> 13, add offset, clamp to 0..1.0
  assign biased  = prod_q + 32'sd4096;
  assign shifted = biased[31:13];
  assign sum     = 20'(shifted) + $signed({4'b0, off2_q});

  always_comb begin
    if (ctl2_q.invalid || !ctl2_q.chan_ok) begin
      value_o = '0;
    end else if (sum[19]) begin
      value_o = '0;
    end else if (sum > $signed({4'b0, OneQ15})) begin
      value_o = OneQ15;
    end else begin
      value_o = sum[DataW-1:0];
    end
  end

  assign ctl_o = ctl2_q;

endmodule

// File: rtl/pdrs_stats.sv
// Range statistics and result register: running min/max, seen flag,
// saturating invalid tally. Depends on pdrs_pkg.
module pdrs_stats #(
  parameter int unsigned COUNT_WIDTH = pdrs_pkg::CountWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [pdrs_pkg::DataW-1:0]     value_i,
  input  pdrs_pkg::pdrs_ctl_t            ctl_i,
  output logic                           out_valid_o,
  output logic [pdrs_pkg::DataW-1:0]     pixel_value_o,
  output logic                           pixel_invalid_o,
  output logic [pdrs_pkg::DataW-1:0]     range_minimum_o,
  output logic [pdrs_pkg::DataW-1:0]     range_maximum_o,
  output logic                           range_seen_o,
  output logic [pdrs_pkg::CountOutW-1:0] invalid_count_o
);
  import pdrs_pkg::*;

  logic [DataW-1:0]       min_q, min_d, max_q, max_d;
  logic                   seen_q, seen_d;
  logic [COUNT_WIDTH-1:0] tally_q, tally_d;
  logic                   out_valid_q;
  logic [DataW-1:0]       val_q;
  logic                   inv_q;

  always_comb begin
    min_d   = ctl_i.start ? OneQ15 : min_q;
    max_d   = ctl_i.start ? '0     : max_q;
    seen_d  = ctl_i.start ? 1'b0   : seen_q;
    tally_d = ctl_i.start ? '0     : tally_q;
    if (ctl_i.invalid) begin
      if (tally_d != '1) tally_d = tally_d + 1'b1;
    end else if (ctl_i.chan_ok) begin
      if (value_i < min_d) min_d = value_i;
      if (value_i > max_d) max_d = value_i;
      seen_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= OneQ15;
      max_q       <= '0;
      seen_q      <= 1'b0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= ctl_i.valid;
      if (ctl_i.valid) begin
        min_q   <= min_d;
        max_q   <= max_d;
        seen_q  <= seen_d;
        tally_q <= tally_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && ctl_i.valid) begin
      val_q <= value_i;
      inv_q <= ctl_i.invalid;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_value_o   = val_q;
  assign pixel_invalid_o = inv_q;
  assign range_minimum_o = min_q;
  assign range_maximum_o = max_q;
  assign range_seen_o    = seen_q;
  assign invalid_count_o = CountOutW'(tally_q);

endmodule

// File: rtl/pixel_denormalize_with_range_stats_core.sv
// Per-channel pixel denormalizer with range statistics, top level.
// Depends on pdrs_pkg, pdrs_ifs, pdrs_cfg, pdrs_scale, pdrs_stats.
//
// Usage:
//   in_i  : valid/ready stream of words (sample Q3.12, color_channel,
//           sample_invalid, frame_start).
//   out_o : valid/ready stream, one result word per input word, in order:
//           pixel_value Q1.15 (0..32768), flag, and the statistics
//           after that word.
//   APB   : gains at 0x00/0x04/0x08, offsets at 0x0C/0x10/0x14; write only
//           while the stream is idle. pready is always high.
//   Pipeline: three register stages (input/select, product, result); a word
//           accepted into the input/select register moves on through the
//           product register into the result register while out_o is not stalled.
//   Throughput: one word per cycle while out_o is not stalled, set by the single product register.
//   Stall: while out_o holds a word that is not taken, the whole pipeline
//           holds and in_i.ready is low; otherwise in_i.ready is high.
//   Reset: clears the pipeline control bits and the statistics (min 32768,
//           max 0, seen 0, tally 0) and loads the default gains and offsets.
module pixel_denormalize_with_range_stats_core #(
  parameter int unsigned COUNT_WIDTH = pdrs_pkg::CountWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pdrs_in_if.sink                     in_i,
  pdrs_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pdrs_pkg::PaddrW-1:0] paddr,
  input  logic [pdrs_pkg::PdataW-1:0] pwdata,
  output logic [pdrs_pkg::PdataW-1:0] prdata,
  output logic                        pready
);
  import pdrs_pkg::*;

  pdrs_cfg_t        cfg;
  pdrs_ctl_t        ctl;
  logic [DataW-1:0] value;
  logic             advance;

  assign advance  = !out_o.valid || out_o.ready;
  assign in_i.ready = advance;

  pdrs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pdrs_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .in_valid_i (in_i.valid),
    .sample_i   (in_i.sample),
    .chan_i     (in_i.color_channel),
    .invalid_i  (in_i.sample_invalid),
    .start_i    (in_i.frame_start),
    .cfg_i      (cfg),
    .value_o    (value),
    .ctl_o      (ctl)
  );

  pdrs_stats #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_stats (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .value_i         (value),
    .ctl_i           (ctl),
    .out_valid_o     (out_o.valid),
    .pixel_value_o   (out_o.pixel_value),
    .pixel_invalid_o (out_o.pixel_invalid),
    .range_minimum_o (out_o.range_minimum),
    .range_maximum_o (out_o.range_maximum),
    .range_seen_o    (out_o.range_seen),
    .invalid_count_o (out_o.invalid_count)
  );

endmodule

// File: rtl/pdrs_checker.sv
// Port-level checks for the pixel denormalizer, bound to the top level.
// Depends on pdrs_pkg and the assertion macro header.
`include "pixel_denormalize_with_range_stats_core_macros.svh"

module pdrs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [pdrs_pkg::DataW-1:0]     pixel_value_i,
  input logic                           pixel_invalid_i,
  input logic [pdrs_pkg::DataW-1:0]     range_minimum_i,
  input logic [pdrs_pkg::DataW-1:0]     range_maximum_i,
  input logic                           range_seen_i
);
  import pdrs_pkg::*;

  `PDRS_ASSERT_ALWAYS(a_no_word_in_reset, !rst_ni |-> !out_valid_i, "result word during reset")

  `PDRS_ASSERT(a_stall_holds, out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_value_i) && $stable(range_minimum_i), "stalled word changed")

  `PDRS_ASSERT(a_ready_when_free, (!out_valid_i || out_ready_i) |-> in_ready_i, "input blocked while output free")

  `PDRS_ASSERT(a_value_range, out_valid_i |-> (pixel_value_i <= OneQ15) && (!pixel_invalid_i || pixel_value_i == '0), "pixel value out of range")

  `PDRS_ASSERT(a_range_order, out_valid_i |-> (range_seen_i ? (range_minimum_i <= range_maximum_i) : (range_minimum_i == OneQ15 && range_maximum_i == '0)), "range statistics inconsistent")

endmodule

bind pixel_denormalize_with_range_stats_core pdrs_checker u_pdrs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .pixel_value_i   (out_o.pixel_value),
  .pixel_invalid_i (out_o.pixel_invalid),
  .range_minimum_i (out_o.range_minimum),
  .range_maximum_i (out_o.range_maximum),
  .range_seen_i    (out_o.range_seen)
);

// File: verif/pixel_denormalize_with_range_stats_core_tb.sv
// Testbench for pixel_denormalize_with_range_stats_core: random and directed sample words,
// gain/offset writes over APB, and a scoreboard that predicts each result word.
// Depends on pdrs_pkg and the pdrs_in_if / pdrs_out_if stream interfaces.
`timescale 1ns / 1ps

module pixel_denormalize_with_range_stats_core_tb;
  import pdrs_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned ItemsPerPhase = 560;

  typedef struct packed {
    logic [DataW-1:0]     pixel_value;
    logic                 pixel_invalid;
    logic [DataW-1:0]     range_minimum;
    logic [DataW-1:0]     range_maximum;
    logic                 range_seen;
    logic [CountOutW-1:0] invalid_count;
  } pixel_word_t;

  class denorm_scoreboard;
    logic [DataW-1:0]         gain [NumChan];
    logic [DataW-1:0]         offset [NumChan];
    logic [DataW-1:0]         run_min;
    logic [DataW-1:0]         run_max;
    logic                     seen;
    logic [CountWidthDef-1:0] tally;
    pixel_word_t              expected_words [$];
    int unsigned              errors;

    function new();
      gain[CH_RED]     = GainRedRst;
      gain[CH_GREEN]   = GainGreenRst;
      gain[CH_BLUE]    = GainBlueRst;
      offset[CH_RED]   = OffsetRedRst;
      offset[CH_GREEN] = OffsetGreenRst;
      offset[CH_BLUE]  = OffsetBlueRst;
      errors = 0;
      clear_stats();
    endfunction

    function void clear_stats();
      run_min = OneQ15;
      run_max = '0;
      seen    = 1'b0;
      tally   = '0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [DataW-1:0] val);
      case (idx)
        REG_GAIN_RED:     gain[CH_RED] = val;
        REG_GAIN_GREEN:   gain[CH_GREEN] = val;
        REG_GAIN_BLUE:    gain[CH_BLUE] = val;
        REG_OFFSET_RED:   offset[CH_RED] = val;
        REG_OFFSET_GREEN: offset[CH_GREEN] = val;
        REG_OFFSET_BLUE:  offset[CH_BLUE] = val;
        default: ;
      endcase
    endfunction

    // Q3.12 * Q0.16, round half up into Q1.15, add offset, clamp to 0..1.0
    function logic [DataW-1:0] denormalize(logic signed [DataW-1:0] s, logic [1:0] ch);
      longint prod;
      longint sum;
      prod = longint'(s) * longint'(gain[ch]);
      sum  = ((prod + 4096) >>> 13) + longint'(offset[ch]);
      if (sum < 0) begin
        sum = 0;
      end else if (sum > longint'(OneQ15)) begin
        sum = longint'(OneQ15);
      end
      return DataW'(sum);
    endfunction

    function void accept_sample(logic signed [DataW-1:0] s, logic [1:0] ch, logic inv,
                                logic start);
      pixel_word_t w;
      w = '0;
      if (start) clear_stats();
      if (inv) begin
        if (tally != '1) tally++;
      end else if (ch != CH_NONE) begin
        w.pixel_value = denormalize(s, ch);
        if (w.pixel_value < run_min) run_min = w.pixel_value;
        if (w.pixel_value > run_max) run_max = w.pixel_value;
        seen = 1'b1;
      end
      w.pixel_invalid = inv;
      w.range_minimum = run_min;
      w.range_maximum = run_max;
      w.range_seen    = seen;
      w.invalid_count = CountOutW'(tally);
      expected_words.insert(expected_words.size(), w);
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    task check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_word(pixel_word_t got);
      pixel_word_t want;
      if (expected_words.size() == 0) begin
        report("result word with no input word pending");
        return;
      end
      want = expected_words.pop_front();
      check_field("pixel_value", got.pixel_value, want.pixel_value);
      check_field("pixel_invalid", got.pixel_invalid, want.pixel_invalid);
      check_field("range_minimum", got.range_minimum, want.range_minimum);
      check_field("range_maximum", got.range_maximum, want.range_maximum);
      check_field("range_seen", got.range_seen, want.range_seen);
      check_field("invalid_count", got.invalid_count, want.invalid_count);
    endtask

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;
  int unsigned       tx_idle_pct;
  int unsigned       rx_stall_pct;
  int unsigned       stall_cycles;
  pixel_word_t       out_word;
  denorm_scoreboard  sb;

  pdrs_in_if  in_if ();
  pdrs_out_if out_if ();

  pixel_denormalize_with_range_stats_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_if.ready <= (rst_ni === 1'b1) && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.accept_sample(in_if.sample, in_if.color_channel, in_if.sample_invalid,
                         in_if.frame_start);
      end
      if (out_if.valid && out_if.ready) begin
        out_word.pixel_value   = out_if.pixel_value;
        out_word.pixel_invalid = out_if.pixel_invalid;
        out_word.range_minimum = out_if.range_minimum;
        out_word.range_maximum = out_if.range_maximum;
        out_word.range_seen    = out_if.range_seen;
        out_word.invalid_count = out_if.invalid_count;
        sb.check_word(out_word);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // starts and ends at a falling edge; valid stays high for back-to-back words
  task send_word(logic signed [DataW-1:0] s, logic [1:0] ch, logic inv, logic start);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.sample         <= s;
    in_if.color_channel  <= ch;
    in_if.sample_invalid <= inv;
    in_if.frame_start    <= start;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task drain_results();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task write_reg(reg_idx_e idx, logic [DataW-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= PdataW'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    sb.set_reg(idx, val);
  endtask

  function logic [DataW-1:0] pick_gain();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return DataW'($urandom_range(65535));
    endcase
  endfunction

  function logic [DataW-1:0] pick_offset();
    case ($urandom_range(5))
      0:       return '0;
      1:       return OneQ15;
      2:       return '1;
      3:       return DataW'($urandom_range(65535));
      default: return DataW'($urandom_range(32768));
    endcase
  endfunction

  task random_config();
    write_reg(REG_GAIN_RED, pick_gain());
    write_reg(REG_GAIN_GREEN, pick_gain());
    write_reg(REG_GAIN_BLUE, pick_gain());
    write_reg(REG_OFFSET_RED, pick_offset());
    write_reg(REG_OFFSET_GREEN, pick_offset());
    write_reg(REG_OFFSET_BLUE, pick_offset());
  endtask

  task run_random(int unsigned n);
    logic signed [DataW-1:0] s;
    logic [1:0]              ch;
    for (int unsigned k = 0; k < n; k++) begin
      if (k == n / 2) drain_results();
      case ($urandom_range(7))
        0:       s = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        1:       s = DataW'($urandom_range(255)) - 16'sd128;
        default: s = DataW'($urandom);
      endcase
      ch = ($urandom_range(15) == 0) ? CH_NONE : 2'($urandom_range(2));
      send_word(s, ch, $urandom_range(7) == 0, $urandom_range(39) == 0);
    end
  endtask

  initial begin
    sb = new();
    rst_ni               = 1'b1;
    in_if.valid          = 1'b0;
    in_if.sample         = '0;
    in_if.color_channel  = CH_RED;
    in_if.sample_invalid = 1'b0;
    in_if.frame_start    = 1'b0;
    out_if.ready         = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    stall_cycles         = 0;
    tx_idle_pct          = 10;
    rx_stall_pct         = 82;
    #1 rst_ni = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // default gains and offsets
    send_word(16'sd0, CH_RED, 1'b0, 1'b1);
    send_word(16'sh7fff, CH_RED, 1'b0, 1'b0);
    send_word(16'sh8000, CH_RED, 1'b0, 1'b0);
    send_word(16'sd4096, CH_GREEN, 1'b0, 1'b0);
    send_word(-16'sd4096, CH_BLUE, 1'b0, 1'b0);
    send_word(16'sd1000, CH_NONE, 1'b0, 1'b0);
    send_word(16'sd1000, CH_NONE, 1'b1, 1'b0);
    send_word(-16'sd1, CH_RED, 1'b1, 1'b0);
    send_word(16'sd77, CH_GREEN, 1'b1, 1'b1);
    send_word(16'sd77, CH_NONE, 1'b0, 1'b1);

    // rounding ties, zero gain, full-scale gain and offsets at and past 1.0
    drain_results();
    write_reg(REG_GAIN_RED, 16'd4096);
    write_reg(REG_GAIN_GREEN, 16'hffff);
    write_reg(REG_GAIN_BLUE, 16'd0);
    write_reg(REG_OFFSET_RED, 16'd0);
    write_reg(REG_OFFSET_GREEN, OneQ15);
    write_reg(REG_OFFSET_BLUE, 16'hffff);
    send_word(16'sd1, CH_RED, 1'b0, 1'b1);
    send_word(-16'sd1, CH_RED, 1'b0, 1'b0);
    send_word(-16'sd3, CH_RED, 1'b0, 1'b0);
    send_word(16'sd3, CH_RED, 1'b0, 1'b0);
    send_word(16'sh7fff, CH_GREEN, 1'b0, 1'b0);
    send_word(16'sh8000, CH_GREEN, 1'b0, 1'b0);
    send_word(16'sd12345, CH_BLUE, 1'b0, 1'b0);
    send_word(16'sh8000, CH_BLUE, 1'b0, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      drain_results();
      random_config();
      tx_idle_pct  = (ph == 0) ? 10 : (ph == 1) ? 82 : 0;
      rx_stall_pct = (ph == 0) ? 82 : (ph == 1) ? 10 : 0;
      run_random(ItemsPerPhase);
    end

    drain_results();
    repeat (8) @(negedge clk_i);
    if (sb.pending() != 0) sb.report("result words still outstanding");
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
